### rtl/amr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_pkg: shared types and constants for the box move-and-resolve block
// Holds the item function codes, configuration register indexes and reset
// values, the control word layout and the microprogram of the sequencer.
// ----------------------------------------------------------------------------
package amr_pkg;

  // Default size of the tile table.
  localparam int MAX_TILES_DEFAULT = 256;

  // Field widths.
  localparam int POS_W    = 32;
  localparam int SIZE_W   = 24;
  localparam int COUNT_W  = 9;
  localparam int FTIME_W  = 16;
  localparam int PROD_W   = FTIME_W + SIZE_W;
  localparam int WIDE_W   = POS_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SIZE_W;

  // Item function codes.
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_PLACE = 2'd1;
  localparam logic [1:0] FUNC_STEP  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIDE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT = 3'd4;

  // Configuration reset values.
  localparam logic [SIZE_W-1:0]  MOVE_SPEED_RST = 24'd65280;
  localparam logic [SIZE_W-1:0]  BOX_WIDTH_RST  = 24'd12288;
  localparam logic [SIZE_W-1:0]  BOX_HEIGHT_RST = 24'd12288;
  localparam logic [SIZE_W-1:0]  TILE_SIDE_RST  = 24'd12288;
  localparam logic [COUNT_W-1:0] TILE_COUNT_RST = 9'd0;

  // Signed 32-bit limits in the wide datapath format.
  localparam logic signed [WIDE_W-1:0] S32_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] S32_MIN = 34'sh3_8000_0000;

  // Datapath operations driven by one control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MUL,
    OP_MOVE,
    OP_READ,
    OP_TEST,
    OP_EMIT
  } op_t;

  // Jump conditions evaluated when a step completes.
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NOT_STEP,
    C_SKIP_WALK,
    C_MORE
  } cond_t;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  // Program counter and step addresses.
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] P_WAIT    = 4'd0;
  localparam logic [PC_W-1:0] P_MUL     = 4'd1;
  localparam logic [PC_W-1:0] P_MOVE_X  = 4'd2;
  localparam logic [PC_W-1:0] P_PRIME_X = 4'd3;
  localparam logic [PC_W-1:0] P_TEST_X  = 4'd4;
  localparam logic [PC_W-1:0] P_MOVE_Y  = 4'd5;
  localparam logic [PC_W-1:0] P_PRIME_Y = 4'd6;
  localparam logic [PC_W-1:0] P_TEST_Y  = 4'd7;
  localparam logic [PC_W-1:0] P_EMIT    = 4'd8;

  typedef struct packed {
    op_t             op;
    logic            axis;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Microprogram: one control word per step.
  function automatic ctrl_t prog_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{OP_NOP, AXIS_X, C_ALWAYS, P_WAIT};
    case (pc)
      P_WAIT:    w = '{OP_ACCEPT, AXIS_X, C_NOT_STEP,  P_EMIT};
      P_MUL:     w = '{OP_MUL,    AXIS_X, C_NONE,      P_WAIT};
      P_MOVE_X:  w = '{OP_MOVE,   AXIS_X, C_NONE,      P_WAIT};
      P_PRIME_X: w = '{OP_READ,   AXIS_X, C_SKIP_WALK, P_MOVE_Y};
      P_TEST_X:  w = '{OP_TEST,   AXIS_X, C_MORE,      P_TEST_X};
      P_MOVE_Y:  w = '{OP_MOVE,   AXIS_Y, C_NONE,      P_WAIT};
      P_PRIME_Y: w = '{OP_READ,   AXIS_Y, C_SKIP_WALK, P_EMIT};
      P_TEST_Y:  w = '{OP_TEST,   AXIS_Y, C_MORE,      P_TEST_Y};
      P_EMIT:    w = '{OP_EMIT,   AXIS_X, C_ALWAYS,    P_WAIT};
      default:   w = '{OP_NOP,    AXIS_X, C_ALWAYS,    P_WAIT};
    endcase
    return w;
  endfunction

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[POS_W-1:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/aabb_move_and_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_move_and_resolve: axis-by-axis box movement against a tile table
// A microcoded sequencer moves one box one axis at a time, walking the tile
// table after each move and snapping the box flush against every tile it overlaps.
// ----------------------------------------------------------------------------
// Usage:
//   The cmd channel (cmd_valid, cmd_stall) carries one item: load a tile,
//   place the box, or run a frame step. The res channel (res_valid,
//   res_stall) returns exactly one result item per command item: the box
//   position after the item and the two snap flags.
//   Load, place and the unused function code occupy the sequencer for the
//   accept step and the result step, and the result register loads at the
//   result step. A frame step runs the accept, multiply, move, prime and
//   tile test steps for x, then the move, prime and tile test steps for y,
//   then the result step, with one tile test per tile walked on each axis
//   (min(tile_count, MAX_TILES), or none for an axis whose key pair gives
//   no direction). The walk is bounded by the single read port of the tile
//   memory, which delivers one tile per cycle.
//   The result sits in an output register; a new item is accepted while it
//   waits. If the receiver stalls, the next result holds the sequencer at its
//   final step until the register frees up.
//   Reset clears the box position to zero, restores the register defaults
//   and empties the result register. Tile contents are undefined until
//   loaded. Configuration is written through cfg_write_en, cfg_index and
//   cfg_data while the block is idle; the user must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module aabb_move_and_resolve #(
  parameter int MAX_TILES = amr_pkg::MAX_TILES_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_write_en,
  input  logic [amr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [amr_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Command channel.
  input  logic                                 cmd_valid,
  output logic                                 cmd_stall,
  input  logic [1:0]                           func,
  input  logic [7:0]                           tile_index,
  input  logic signed [amr_pkg::POS_W-1:0]     pos_x,
  input  logic signed [amr_pkg::POS_W-1:0]     pos_y,
  input  logic                                 key_left,
  input  logic                                 key_right,
  input  logic                                 key_up,
  input  logic                                 key_down,
  input  logic [amr_pkg::FTIME_W-1:0]          frame_time,
  // Result channel.
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic signed [amr_pkg::POS_W-1:0]     box_x,
  output logic signed [amr_pkg::POS_W-1:0]     box_y,
  output logic                                 hit_horizontal,
  output logic                                 hit_vertical
);

  localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CW = $clog2(MAX_TILES + 1);
  localparam int PW = amr_pkg::POS_W;
  localparam int WW = amr_pkg::WIDE_W;

  // Configuration registers.
  logic [amr_pkg::SIZE_W-1:0]  move_speed;
  logic [amr_pkg::SIZE_W-1:0]  box_width;
  logic [amr_pkg::SIZE_W-1:0]  box_height;
  logic [amr_pkg::SIZE_W-1:0]  tile_side;
  logic [amr_pkg::COUNT_W-1:0] tile_count;

  // Sequencer and datapath state.
  logic [amr_pkg::PC_W-1:0]    pc;
  logic [amr_pkg::PC_W-1:0]    pc_next;
  logic [CW-1:0]               cnt;
  logic signed [PW-1:0]        box_pos_x;
  logic signed [PW-1:0]        box_pos_y;
  logic [amr_pkg::FTIME_W-1:0] ftime;
  logic [amr_pkg::PROD_W-1:0]  prod;
  logic                        left_held;
  logic                        right_held;
  logic                        up_held;
  logic                        down_held;
  logic                        hit_h;
  logic                        hit_v;

  // Tile memory: y in the upper half, x in the lower half.
  logic [2*PW-1:0]             tile_mem [MAX_TILES];
  logic [2*PW-1:0]             tile_rd;
  logic                        mem_we;

  amr_pkg::ctrl_t              ctrl;
  logic                        cmd_take;
  logic                        hold;
  logic                        cond_true;
  logic                        walk_end;

  logic                        dir_neg;
  logic                        dir_pos;
  logic                        dir_zero;
  logic signed [PW-1:0]        box_cur;
  logic signed [WW-1:0]        move_dist;
  logic signed [WW-1:0]        move_sum;
  logic signed [PW-1:0]        move_pos;
  logic signed [WW-1:0]        tx;
  logic signed [WW-1:0]        ty;
  logic signed [WW-1:0]        bx;
  logic signed [WW-1:0]        by;
  logic signed [WW-1:0]        ts;
  logic signed [WW-1:0]        bw;
  logic signed [WW-1:0]        bh;
  logic                        overlap;
  logic signed [WW-1:0]        tile_coord;
  logic signed [WW-1:0]        box_size;
  logic signed [PW-1:0]        snap_pos;

  // Current control word and step handshakes.
  assign ctrl      = amr_pkg::prog_rom(pc);
  assign cmd_stall = (ctrl.op != amr_pkg::OP_ACCEPT);
  assign cmd_take  = cmd_valid && !cmd_stall;

  always_comb begin
    case (ctrl.op)
      amr_pkg::OP_ACCEPT: hold = !cmd_valid;
      amr_pkg::OP_EMIT:   hold = res_valid && res_stall;
      default:            hold = 1'b0;
    endcase
  end

  // The walk ends when the counter reaches the end of the used part of the table.
  assign walk_end = (32'(cnt) >= 32'(tile_count)) || (32'(cnt) >= MAX_TILES);

  // Direction of the axis named by the control word.
  assign dir_neg  = (ctrl.axis == amr_pkg::AXIS_Y) ? up_held : left_held;
  assign dir_pos  = (ctrl.axis == amr_pkg::AXIS_Y) ? down_held : right_held;
  assign dir_zero = (dir_neg == dir_pos);

  always_comb begin
    case (ctrl.cond)
      amr_pkg::C_NONE:      cond_true = 1'b0;
      amr_pkg::C_ALWAYS:    cond_true = 1'b1;
      amr_pkg::C_NOT_STEP:  cond_true = (func != amr_pkg::FUNC_STEP);
      amr_pkg::C_SKIP_WALK: cond_true = dir_zero || walk_end;
      amr_pkg::C_MORE:      cond_true = !walk_end;
      default:              cond_true = 1'b0;
    endcase
  end

  // Next step: stay while held, else jump or fall through.
  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (cond_true) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + amr_pkg::PC_W'(1);
    end
  end

  // Movement along the current axis by the truncated product.
  assign box_cur   = (ctrl.axis == amr_pkg::AXIS_Y) ? box_pos_y : box_pos_x;
  assign move_dist = $signed(WW'(prod[amr_pkg::PROD_W-1:amr_pkg::FTIME_W]));
  always_comb begin
    if (dir_zero) begin
      move_sum = WW'(box_cur);
    end else if (dir_pos) begin
      move_sum = WW'(box_cur) + move_dist;
    end else begin
      move_sum = WW'(box_cur) - move_dist;
    end
  end
  assign move_pos = amr_pkg::sat32(move_sum);

  // Strict overlap test of the box against the tile just read.
  assign tx = WW'($signed(tile_rd[PW-1:0]));
  assign ty = WW'($signed(tile_rd[2*PW-1:PW]));
  assign bx = WW'(box_pos_x);
  assign by = WW'(box_pos_y);
  assign ts = $signed(WW'(tile_side));
  assign bw = $signed(WW'(box_width));
  assign bh = $signed(WW'(box_height));
  assign overlap = (bx < tx + ts) && (tx < bx + bw) && (by < ty + ts) && (ty < by + bh);

  // Flush position on the side the box came from.
  assign tile_coord = (ctrl.axis == amr_pkg::AXIS_Y) ? ty : tx;
  assign box_size   = (ctrl.axis == amr_pkg::AXIS_Y) ? bh : bw;
  assign snap_pos   = amr_pkg::sat32(dir_pos ? (tile_coord - box_size) : (tile_coord + ts));

  // Tile writes come straight from an accepted load item.
  assign mem_we = cmd_take && (func == amr_pkg::FUNC_LOAD) && (32'(tile_index) < MAX_TILES);

  // Tile memory: one write port, one registered read port at the counter.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tile_mem[AW'(tile_index)] <= {pos_y, pos_x};
    end
    tile_rd <= tile_mem[AW'(cnt)];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      move_speed <= amr_pkg::MOVE_SPEED_RST;
      box_width  <= amr_pkg::BOX_WIDTH_RST;
      box_height <= amr_pkg::BOX_HEIGHT_RST;
      tile_side  <= amr_pkg::TILE_SIDE_RST;
      tile_count <= amr_pkg::TILE_COUNT_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        amr_pkg::REG_MOVE_SPEED: move_speed <= cfg_data;
        amr_pkg::REG_BOX_WIDTH:  box_width  <= cfg_data;
        amr_pkg::REG_BOX_HEIGHT: box_height <= cfg_data;
        amr_pkg::REG_TILE_SIDE:  tile_side  <= cfg_data;
        amr_pkg::REG_TILE_COUNT: tile_count <= cfg_data[amr_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, datapath registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= amr_pkg::P_WAIT;
      res_valid <= 1'b0;
      box_pos_x <= '0;
      box_pos_y <= '0;
      hit_h     <= 1'b0;
      hit_v     <= 1'b0;
    end else begin
      pc <= pc_next;

      // A taken result frees the register unless the result step reloads it.
      if (res_valid && !res_stall && (ctrl.op != amr_pkg::OP_EMIT)) begin
        res_valid <= 1'b0;
      end

      case (ctrl.op)
        amr_pkg::OP_ACCEPT: begin
          if (cmd_take) begin
            ftime      <= frame_time;
            left_held  <= key_left;
            right_held <= key_right;
            up_held    <= key_up;
            down_held  <= key_down;
            hit_h      <= 1'b0;
            hit_v      <= 1'b0;
            if (func == amr_pkg::FUNC_PLACE) begin
              box_pos_x <= pos_x;
              box_pos_y <= pos_y;
            end
          end
        end
        amr_pkg::OP_MUL: begin
          prod <= ftime * move_speed;
        end
        amr_pkg::OP_MOVE: begin
          cnt <= '0;
          if (ctrl.axis == amr_pkg::AXIS_Y) begin
            box_pos_y <= move_pos;
          end else begin
            box_pos_x <= move_pos;
          end
        end
        amr_pkg::OP_READ: begin
          cnt <= cnt + CW'(1);
        end
        amr_pkg::OP_TEST: begin
          cnt <= cnt + CW'(1);
          if (overlap) begin
            if (ctrl.axis == amr_pkg::AXIS_Y) begin
              box_pos_y <= snap_pos;
              hit_v     <= 1'b1;
            end else begin
              box_pos_x <= snap_pos;
              hit_h     <= 1'b1;
            end
          end
        end
        amr_pkg::OP_EMIT: begin
          if (!hold) begin
            res_valid      <= 1'b1;
            box_x          <= box_pos_x;
            box_y          <= box_pos_y;
            hit_horizontal <= hit_h;
            hit_vertical   <= hit_v;
          end
        end
        default: ;
      endcase
    end
  end

  // A tile test always follows a read that primed the memory port.
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == amr_pkg::OP_TEST) |->
      ($past(ctrl.op) == amr_pkg::OP_READ || $past(ctrl.op) == amr_pkg::OP_TEST))
    else $error("tile test without a primed read");

  // Non-step items go straight to the result step.
  assert property (@(posedge clk) disable iff (rst)
    (cmd_take && func != amr_pkg::FUNC_STEP) |=> (ctrl.op == amr_pkg::OP_EMIT))
    else $error("non-step item did not go to the result step");

  // A horizontal snap needs a horizontal direction.
  assert property (@(posedge clk) disable iff (rst)
    hit_h |-> (left_held != right_held))
    else $error("horizontal snap without a direction");

  // A result only appears from the result step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(ctrl.op == amr_pkg::OP_EMIT))
    else $error("result appeared outside the result step");

endmodule
